/* sv/clp_pkg.sv */
// ----------------------------------------------------------------------------
// clp_pkg
// shared constants, types and tables of the complex log / polar core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package clp_pkg;

    // sample and pipeline sizing
    localparam int SAMPLE_WIDTH  = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int LOG_FRAC_BITS = 24;
    localparam int NUM_CELLS     = (CORDIC_STAGES > LOG_FRAC_BITS) ? CORDIC_STAGES
                                                                    : LOG_FRAC_BITS;
    localparam int STAGE_W       = $clog2(NUM_CELLS);

    // front end and back end register depths
    localparam int FRONT_STAGES  = 5;
    localparam int BACK_STAGES   = 3;
    localparam int PIPE_DEPTH    = FRONT_STAGES + NUM_CELLS + BACK_STAGES;

    // datapath widths
    localparam int SQ_W       = 2 * SAMPLE_WIDTH;
    localparam int EXP_W      = $clog2(SQ_W);
    localparam int MANT_W     = 31;
    localparam int GUARD_BITS = 60 - SAMPLE_WIDTH;
    localparam int XY_W       = 64;
    localparam int Z_W        = 36;
    localparam int T_W        = EXP_W + LOG_FRAC_BITS + 1;
    localparam int OUT_W      = 16;

    // log scaling
    localparam int LOG_SHIFT = LOG_FRAC_BITS + 30 + 1 - 10;
    localparam logic signed [31:0]      LN2_Q30       = 32'sd744261118;
    localparam logic signed [T_W-1:0]   LOG_OFFSET    =
        T_W'(longint'(2 * (SAMPLE_WIDTH - 1)) << LOG_FRAC_BITS);
    localparam logic signed [OUT_W-1:0] LOG_FLOOR_Q10 = -16'sd23579;

    // phase scaling
    localparam int PHASE_SHIFT = 17;
    localparam logic signed [Z_W-1:0]   PI_Q30        = Z_W'(64'd3373259426);
    localparam logic signed [Z_W-1:0]   PHASE_ROUND   = Z_W'(64'd65536);
    localparam logic signed [Z_W-1:0]   PHASE_MAX_Z   = Z_W'(64'd25736);
    localparam logic signed [OUT_W-1:0] PHASE_MAX_Q13 = 16'sd25736;

    // data handed from cell to cell
    typedef struct packed {
        logic                     zero;
        logic [EXP_W-1:0]         expo;
        logic [MANT_W-1:0]        mant;
        logic [LOG_FRAC_BITS-1:0] frac;
        logic signed [XY_W-1:0]   x;
        logic signed [XY_W-1:0]   y;
        logic signed [Z_W-1:0]    z;
    } cell_t;

    // atan(2^-i) in Q30, truncated
    function automatic logic [31:0] atan_q30(input logic [4:0] idx);
        logic [31:0] res;
        case (idx)
            5'd0:    res = 32'h3243F6A8;
            5'd1:    res = 32'h1DAC6705;
            5'd2:    res = 32'h0FADBAFC;
            5'd3:    res = 32'h07F56EA6;
            5'd4:    res = 32'h03FEAB76;
            5'd5:    res = 32'h01FFD55B;
            5'd6:    res = 32'h00FFFAAA;
            5'd7:    res = 32'h007FFF55;
            5'd8:    res = 32'h003FFFEA;
            5'd9:    res = 32'h001FFFFD;
            5'd10:   res = 32'h000FFFFF;
            5'd11:   res = 32'h0007FFFF;
            5'd12:   res = 32'h0003FFFF;
            5'd13:   res = 32'h0001FFFF;
            5'd14:   res = 32'h0000FFFF;
            5'd15:   res = 32'h00007FFF;
            5'd16:   res = 32'h00003FFF;
            5'd17:   res = 32'h00001FFF;
            5'd18:   res = 32'h00000FFF;
            5'd19:   res = 32'h000007FF;
            5'd20:   res = 32'h000003FF;
            5'd21:   res = 32'h000001FF;
            5'd22:   res = 32'h000000FF;
            5'd23:   res = 32'h0000007F;
            5'd24:   res = 32'h0000003F;
            5'd25:   res = 32'h0000001F;
            5'd26:   res = 32'h0000000F;
            5'd27:   res = 32'h00000007;
            5'd28:   res = 32'h00000003;
            5'd29:   res = 32'h00000001;
            default: res = 32'h00000000;
        endcase
        return res;
    endfunction

endpackage

/* sv/clp_front.sv */
// ----------------------------------------------------------------------------
// clp_front
// input register, squares, half-plane fold, sum of squares and normalisation
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clp_front (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   take,
    input  logic signed [clp_pkg::SAMPLE_WIDTH-1:0] real_part,
    input  logic signed [clp_pkg::SAMPLE_WIDTH-1:0] imag_part,
    output logic                                   valid_out,
    output clp_pkg::cell_t                         data_out
);
    import clp_pkg::*;

    // stage 1: sample register
    logic                           v1_reg;
    logic signed [SAMPLE_WIDTH-1:0] re_reg;
    logic signed [SAMPLE_WIDTH-1:0] im_reg;

    // stage 2: squares and folded vector
    logic                    v2_reg;
    logic [SQ_W-1:0]         sqr_reg;
    logic [SQ_W-1:0]         sqi_reg;
    logic signed [XY_W-1:0]  x2_reg;
    logic signed [XY_W-1:0]  y2_reg;
    logic signed [Z_W-1:0]   z2_reg;
    logic signed [SQ_W-1:0]  sqr_next;
    logic signed [SQ_W-1:0]  sqi_next;
    logic signed [XY_W-1:0]  re_ext;
    logic signed [XY_W-1:0]  im_ext;
    logic signed [XY_W-1:0]  x2_next;
    logic signed [XY_W-1:0]  y2_next;
    logic signed [Z_W-1:0]   z2_next;

    // stage 3: sum of squares
    logic                    v3_reg;
    logic [SQ_W-1:0]         sum_reg;
    logic signed [XY_W-1:0]  x3_reg;
    logic signed [XY_W-1:0]  y3_reg;
    logic signed [Z_W-1:0]   z3_reg;

    // stage 4: leading one search
    logic                    v4_reg;
    logic [SQ_W-1:0]         sum4_reg;
    logic [EXP_W-1:0]        expo_reg;
    logic [EXP_W-1:0]        expo_next;
    logic                    zero_reg;
    logic signed [XY_W-1:0]  x4_reg;
    logic signed [XY_W-1:0]  y4_reg;
    logic signed [Z_W-1:0]   z4_reg;

    // stage 5: mantissa alignment
    logic [SQ_W+MANT_W-2:0]  norm_wide;
    logic                    v5_reg;
    cell_t                   data_reg;
    cell_t                   data_next;

    // valid shift through the front end
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= take;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // squares and fold into the right half plane
    always_comb
    begin
        sqr_next = SQ_W'(re_reg) * SQ_W'(re_reg);
        sqi_next = SQ_W'(im_reg) * SQ_W'(im_reg);
        re_ext   = XY_W'(re_reg);
        im_ext   = XY_W'(im_reg);
        if (re_reg[SAMPLE_WIDTH-1])
        begin
            x2_next = (-re_ext) <<< GUARD_BITS;
            y2_next = (-im_ext) <<< GUARD_BITS;
            z2_next = im_reg[SAMPLE_WIDTH-1] ? -PI_Q30 : PI_Q30;
        end
        else
        begin
            x2_next = re_ext <<< GUARD_BITS;
            y2_next = im_ext <<< GUARD_BITS;
            z2_next = '0;
        end
    end

    // position of the leading one of the sum
    always_comb
    begin
        expo_next = '0;
        for (int i = 0; i < SQ_W; i++)
        begin
            if (sum_reg[i])
            begin
                expo_next = EXP_W'(i);
            end
        end
    end

    // align the leading one to bit 30, low bits truncated
    always_comb
    begin
        norm_wide           = {sum4_reg, {(MANT_W-1){1'b0}}} >> expo_reg;
        data_next.zero      = zero_reg;
        data_next.expo      = expo_reg;
        data_next.mant      = norm_wide[MANT_W-1:0];
        data_next.frac      = '0;
        data_next.x         = x4_reg;
        data_next.y         = y4_reg;
        data_next.z         = z4_reg;
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        re_reg   <= real_part;
        im_reg   <= imag_part;
        sqr_reg  <= $unsigned(sqr_next);
        sqi_reg  <= $unsigned(sqi_next);
        x2_reg   <= x2_next;
        y2_reg   <= y2_next;
        z2_reg   <= z2_next;
        sum_reg  <= sqr_reg + sqi_reg;
        x3_reg   <= x2_reg;
        y3_reg   <= y2_reg;
        z3_reg   <= z2_reg;
        sum4_reg <= sum_reg;
        expo_reg <= expo_next;
        zero_reg <= (sum_reg == '0);
        x4_reg   <= x3_reg;
        y4_reg   <= y3_reg;
        z4_reg   <= z3_reg;
        data_reg <= data_next;
    end

    assign valid_out = v5_reg;
    assign data_out  = data_reg;

endmodule

/* sv/clp_cell.sv */
// ----------------------------------------------------------------------------
// clp_cell
// one cell of the chain: a log2 squaring step and a cordic vectoring step
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clp_cell (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic [clp_pkg::STAGE_W-1:0]   stage,
    input  logic                          valid_in,
    input  clp_pkg::cell_t                data_in,
    output logic                          valid_out,
    output clp_pkg::cell_t                data_out
);
    import clp_pkg::*;

    logic                    valid_reg;
    cell_t                   data_reg;
    cell_t                   data_next;
    logic [2*MANT_W-1:0]     mant_sq;
    logic [MANT_W:0]         mant_q;
    logic signed [XY_W-1:0]  x_sh;
    logic signed [XY_W-1:0]  y_sh;
    logic signed [Z_W-1:0]   angle;

    // squaring step and rotation towards the real axis
    always_comb
    begin
        data_next = data_in;
        mant_sq   = (2*MANT_W)'(data_in.mant) * (2*MANT_W)'(data_in.mant);
        mant_q    = mant_sq[2*MANT_W-1:MANT_W-1];
        x_sh      = data_in.x >>> stage;
        y_sh      = data_in.y >>> stage;
        angle     = $signed({{(Z_W-32){1'b0}}, atan_q30(5'(stage))});

        // mantissa squared; a carry past two gives the next fraction bit
        if (int'(stage) < LOG_FRAC_BITS)
        begin
            if (mant_q[MANT_W])
            begin
                data_next.mant = mant_q[MANT_W:1];
                data_next.frac = {data_in.frac[LOG_FRAC_BITS-2:0], 1'b1};
            end
            else
            begin
                data_next.mant = mant_q[MANT_W-1:0];
                data_next.frac = {data_in.frac[LOG_FRAC_BITS-2:0], 1'b0};
            end
        end

        // a zero residue leaves the vector alone
        if (int'(stage) < CORDIC_STAGES)
        begin
            if (data_in.y > 0)
            begin
                data_next.x = data_in.x + y_sh;
                data_next.y = data_in.y - x_sh;
                data_next.z = data_in.z + angle;
            end
            else if (data_in.y < 0)
            begin
                data_next.x = data_in.x - y_sh;
                data_next.y = data_in.y + x_sh;
                data_next.z = data_in.z - angle;
            end
        end
    end

    // valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_in;
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign valid_out = valid_reg;
    assign data_out  = data_reg;

endmodule

/* sv/clp_back.sv */
// ----------------------------------------------------------------------------
// clp_back
// log2 to ln scaling, phase rounding and saturation, result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clp_back (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                valid_in,
    input  clp_pkg::cell_t                      data_in,
    output logic                                done,
    output logic signed [clp_pkg::OUT_W-1:0]    log_magnitude,
    output logic signed [clp_pkg::OUT_W-1:0]    phase_angle
);
    import clp_pkg::*;

    logic                     v1_reg;
    logic                     v2_reg;
    logic                     v3_reg;
    logic signed [T_W-1:0]    t_reg;
    logic signed [T_W-1:0]    t_next;
    logic                     zero1_reg;
    logic                     zero2_reg;
    logic signed [OUT_W-1:0]  ph1_reg;
    logic signed [OUT_W-1:0]  ph2_reg;
    logic signed [OUT_W-1:0]  ph_next;
    logic signed [Z_W-1:0]    z_round;
    logic signed [Z_W-1:0]    z_shift;
    logic signed [T_W+31:0]   prod_reg;
    logic signed [T_W+31:0]   prod_next;
    logic signed [OUT_W-1:0]  log_reg;
    logic signed [OUT_W-1:0]  log_next;
    logic signed [OUT_W-1:0]  phase_reg;

    // log2 relative to full scale, phase rounded half up and clamped to pi
    always_comb
    begin
        t_next  = $signed({1'b0, data_in.expo, data_in.frac}) - LOG_OFFSET;
        z_round = data_in.z + PHASE_ROUND;
        z_shift = z_round >>> PHASE_SHIFT;
        if (z_shift > PHASE_MAX_Z)
        begin
            ph_next = PHASE_MAX_Q13;
        end
        else if (z_shift < -PHASE_MAX_Z)
        begin
            ph_next = -PHASE_MAX_Q13;
        end
        else
        begin
            ph_next = OUT_W'(z_shift);
        end
    end

    // scale by ln2 and halve; the range never leaves 16 bits
    assign prod_next = t_reg * LN2_Q30;

    // zero vector takes the clamped floor
    assign log_next = zero2_reg ? LOG_FLOOR_Q10 : prod_reg[LOG_SHIFT +: OUT_W];

    // valid shift and result strobe
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= valid_in;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        t_reg     <= t_next;
        zero1_reg <= data_in.zero;
        ph1_reg   <= ph_next;
        prod_reg  <= prod_next;
        zero2_reg <= zero1_reg;
        ph2_reg   <= ph1_reg;
        log_reg   <= log_next;
        phase_reg <= ph2_reg;
    end

    assign done          = v3_reg;
    assign log_magnitude = log_reg;
    assign phase_angle   = phase_reg;

endmodule

/* sv/complex_log_polar_core.sv */
// ----------------------------------------------------------------------------
// complex_log_polar_core
// the result strobe of a request rises once it has passed 5 front end stages,
// 24 chain cells and 3 back end stages; the depth of the chain is set
// by the 24 mantissa squaring steps of the log2
// throughput: one sample per clock cycle; busy is never raised and results
// are not held back, as the receiver cannot stall
// reset: rst_n clears every valid flag at once, so no result follows a reset
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module complex_log_polar_core (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic signed [clp_pkg::SAMPLE_WIDTH-1:0] real_part,
    input  logic signed [clp_pkg::SAMPLE_WIDTH-1:0] imag_part,
    output logic                                    busy,
    output logic                                    done,
    output logic signed [clp_pkg::OUT_W-1:0]        log_magnitude,
    output logic signed [clp_pkg::OUT_W-1:0]        phase_angle
);
    import clp_pkg::*;

    logic  take;
    logic  chain_valid [NUM_CELLS+1];
    cell_t chain_data  [NUM_CELLS+1];

    // the pipeline takes a request every cycle
    assign busy = 1'b0;
    assign take = start && !busy;

    // front end
    clp_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .real_part (real_part),
        .imag_part (imag_part),
        .valid_out (chain_valid[0]),
        .data_out  (chain_data[0])
    );

    // chain of squaring and rotation cells
    for (genvar i = 0; i < NUM_CELLS; i++)
    begin : g_cell
        clp_cell u_cell (
            .clk       (clk),
            .rst_n     (rst_n),
            .stage     (STAGE_W'(i)),
            .valid_in  (chain_valid[i]),
            .data_in   (chain_data[i]),
            .valid_out (chain_valid[i+1]),
            .data_out  (chain_data[i+1])
        );
    end

    // back end
    clp_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .valid_in      (chain_valid[NUM_CELLS]),
        .data_in       (chain_data[NUM_CELLS]),
        .done          (done),
        .log_magnitude (log_magnitude),
        .phase_angle   (phase_angle)
    );

    // every request gives a strobe after the full depth
    a_req_to_done: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> ##PIPE_DEPTH done)
        else $error("request without result strobe");

    // no strobe without a request the full depth earlier
    a_done_from_req: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start, PIPE_DEPTH))
        else $error("result strobe without request");

    // zero vector gives the clamped log and zero phase
    a_zero_vector: assert property (@(posedge clk) disable iff (!rst_n)
        (start && real_part == '0 && imag_part == '0) |-> ##PIPE_DEPTH
        (log_magnitude == LOG_FLOOR_Q10 && phase_angle == '0))
        else $error("zero vector result wrong");

    // negative real axis gives exactly +pi
    a_neg_axis: assert property (@(posedge clk) disable iff (!rst_n)
        (start && real_part[SAMPLE_WIDTH-1] && imag_part == '0) |-> ##PIPE_DEPTH
        (phase_angle == PHASE_MAX_Q13))
        else $error("negative real axis phase not pi");

    // phase stays within plus or minus pi
    a_phase_range: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (phase_angle <= PHASE_MAX_Q13 && phase_angle >= -PHASE_MAX_Q13))
        else $error("phase out of range");

endmodule

/* tb/clp_checker.sv */
// ----------------------------------------------------------------------------
// clp_checker
// watches the request and result channels of complex_log_polar_core, predicts
// ln|z| and the four-quadrant angle of every accepted sample and compares each
// result strobe, field by field, with the oldest prediction waiting
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module clp_checker (
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    start,
    input  logic                                    busy,
    input  logic signed [clp_pkg::SAMPLE_WIDTH-1:0] real_part,
    input  logic signed [clp_pkg::SAMPLE_WIDTH-1:0] imag_part,
    input  logic                                    done,
    input  logic signed [clp_pkg::OUT_W-1:0]        log_magnitude,
    input  logic signed [clp_pkg::OUT_W-1:0]        phase_angle,
    output int                                      fail_count,
    output int                                      pending_count,
    output int                                      checked_count
);

    import clp_pkg::*;

    localparam int     LOG2_FRAC   = 24;
    localparam longint LN2_Q30_VAL = 64'sd744261118;
    localparam longint PI_Q30_VAL  = 64'sd3373259426;
    localparam longint LOG_CLAMP   = -64'sd23579;
    localparam longint PHASE_LIMIT = 64'sd25736;

    typedef struct {
        logic signed [15:0] log_mag;
        logic signed [15:0] phase;
    } polar_result_t;

    // arctangent of 2^-i in Q30, truncated
    longint atan_steps [0:31] = '{
        64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
        64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
        64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
        64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
        64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
        64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003, 64'h00000001,
        64'h00000000, 64'h00000000
    };

    polar_result_t expected_polar [$];
    int            err_total;
    int            seen_total;

    // natural log of the magnitude, Q10, through a squaring log2 of re^2 + im^2
    function automatic logic signed [15:0] predict_log_mag(input longint re,
                                                           input longint im);
        longint unsigned sq;
        longint unsigned mant;
        longint unsigned frac;
        longint          log2_val;
        longint          scaled;
        longint          r;
        int              msb;
        sq = longint'(re * re + im * im);
        if (sq == 0)
            return 16'(LOG_CLAMP);
        msb = 63;
        while (sq[msb] == 1'b0)
            msb--;
        if (msb > 30)
            mant = sq >> (msb - 30);
        else
            mant = sq << (30 - msb);
        frac = 0;
        for (int k = LOG2_FRAC - 1; k >= 0; k--)
        begin
            mant = (mant * mant) >> 30;
            if (mant >= (64'd1 << 31))
            begin
                mant = mant >> 1;
                frac = frac | (64'd1 << k);
            end
        end
        log2_val = ((longint'(msb) << LOG2_FRAC) | longint'(frac))
                   - (longint'(2 * (SAMPLE_WIDTH - 1)) << LOG2_FRAC);
        scaled = log2_val * LN2_Q30_VAL;
        r = scaled >>> (LOG2_FRAC + 30 + 1 - 10);
        if (r > 32767)
            r = 32767;
        if (r < -32768)
            r = -32768;
        return 16'(r);
    endfunction

    // cordic vectoring after a fold into the right half plane, Q13 radians
    function automatic logic signed [15:0] predict_phase(input longint re,
                                                         input longint im);
        longint x;
        longint y;
        longint z;
        longint xs;
        longint ys;
        longint r;
        x = re;
        y = im;
        z = 0;
        if (x < 0)
        begin
            z = (im >= 0) ? PI_Q30_VAL : -PI_Q30_VAL;
            x = -x;
            y = -y;
        end
        x = x <<< (60 - SAMPLE_WIDTH);
        y = y <<< (60 - SAMPLE_WIDTH);
        for (int i = 0; i < CORDIC_STAGES && i < 32; i++)
        begin
            xs = x >>> i;
            ys = y >>> i;
            if (y > 0)
            begin
                x = x + ys;
                y = y - xs;
                z = z + atan_steps[i];
            end
            else if (y < 0)
            begin
                x = x - ys;
                y = y + xs;
                z = z - atan_steps[i];
            end
        end
        r = (z + (64'sd1 <<< 16)) >>> 17;
        if (r > PHASE_LIMIT)
            r = PHASE_LIMIT;
        if (r < -PHASE_LIMIT)
            r = -PHASE_LIMIT;
        return 16'(r);
    endfunction

    initial
    begin
        err_total     = 0;
        seen_total    = 0;
        fail_count    = 0;
        pending_count = 0;
        checked_count = 0;
    end

    // compare result strobes, then queue the prediction for a new request
    always @(posedge clk)
    begin
        polar_result_t want;
        polar_result_t got;
        if (rst_n)
        begin
            if (done)
            begin
                got.log_mag = log_magnitude;
                got.phase   = phase_angle;
                if (expected_polar.size() == 0)
                begin
                    $error("result with nothing expected: log_magnitude %0d phase_angle %0d",
                           got.log_mag, got.phase);
                    err_total++;
                end
                else
                begin
                    want = expected_polar.pop_front();
                    seen_total++;
                    if (got.log_mag !== want.log_mag)
                    begin
                        $error("log_magnitude: expected %0d, actual %0d",
                               want.log_mag, got.log_mag);
                        err_total++;
                    end
                    if (got.phase !== want.phase)
                    begin
                        $error("phase_angle: expected %0d, actual %0d",
                               want.phase, got.phase);
                        err_total++;
                    end
                end
            end
            if (start && !busy)
            begin
                want.log_mag = predict_log_mag(longint'(real_part), longint'(imag_part));
                want.phase   = predict_phase(longint'(real_part), longint'(imag_part));
                expected_polar.push_back(want);
            end
        end
        fail_count    <= err_total;
        pending_count <= expected_polar.size();
        checked_count <= seen_total;
    end

endmodule

/* tb/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Drives complex_log_polar_core with directed corner samples (zero vector,
// both real half-axes, full-scale extremes, tiny magnitudes) and then a
// random mix of samples with idle gaps; clp_checker predicts and compares
// every result and this module gives the verdict.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

    import clp_pkg::*;

    localparam int RANDOM_REQUESTS = 1700;
    localparam int DRAIN_CYCLES    = 40;

    logic                           clk;
    logic                           rst_n;
    logic                           start;
    logic signed [SAMPLE_WIDTH-1:0] real_part;
    logic signed [SAMPLE_WIDTH-1:0] imag_part;
    logic                           busy;
    logic                           done;
    logic signed [OUT_W-1:0]        log_magnitude;
    logic signed [OUT_W-1:0]        phase_angle;

    int fail_count;
    int pending_count;
    int checked_count;
    int sent_count;

    complex_log_polar_core DUT (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .real_part     (real_part),
        .imag_part     (imag_part),
        .busy          (busy),
        .done          (done),
        .log_magnitude (log_magnitude),
        .phase_angle   (phase_angle)
    );

    clp_checker polar_check (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .real_part     (real_part),
        .imag_part     (imag_part),
        .done          (done),
        .log_magnitude (log_magnitude),
        .phase_angle   (phase_angle),
        .fail_count    (fail_count),
        .pending_count (pending_count),
        .checked_count (checked_count)
    );

    // 2 ns clock
    initial
        clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // present one sample and hold it until the request is taken
    task automatic send_sample(input logic signed [SAMPLE_WIDTH-1:0] re,
                               input logic signed [SAMPLE_WIDTH-1:0] im);
        @(negedge clk);
        start     = 1'b1;
        real_part = re;
        imag_part = im;
        do
            @(posedge clk);
        while (busy);
        sent_count++;
    endtask

    task automatic idle_cycle();
        @(negedge clk);
        start = 1'b0;
        @(posedge clk);
    endtask

    // one random sample, weighted towards awkward regions of the plane
    task automatic send_random_sample();
        logic signed [SAMPLE_WIDTH-1:0] re;
        logic signed [SAMPLE_WIDTH-1:0] im;
        logic signed [SAMPLE_WIDTH-1:0] picks [5];
        int                             kind;
        picks = '{-16'sd32768, -16'sd1, 16'sd0, 16'sd1, 16'sd32767};
        kind  = $urandom_range(0, 99);
        re    = SAMPLE_WIDTH'($urandom());
        im    = SAMPLE_WIDTH'($urandom());
        if (kind >= 60 && kind < 70)
        begin
            // tiny magnitudes, deep into the log range
            re = SAMPLE_WIDTH'(int'($urandom_range(0, 16)) - 8);
            im = SAMPLE_WIDTH'(int'($urandom_range(0, 16)) - 8);
        end
        else if (kind >= 70 && kind < 80)
        begin
            // on one of the axes
            if ($urandom_range(0, 1))
                re = '0;
            else
                im = '0;
        end
        else if (kind >= 80 && kind < 88)
        begin
            // diagonals, equal magnitudes
            re = SAMPLE_WIDTH'($urandom_range(0, 32767));
            im = $urandom_range(0, 1) ? -re : re;
            if ($urandom_range(0, 1))
                re = -re;
        end
        else if (kind >= 88 && kind < 95)
        begin
            // close to the negative real axis
            re = -SAMPLE_WIDTH'($urandom_range(1, 32768));
            im = SAMPLE_WIDTH'(int'($urandom_range(0, 4)) - 2);
        end
        else if (kind >= 95)
        begin
            re = picks[$urandom_range(0, 4)];
            im = picks[$urandom_range(0, 4)];
        end
        send_sample(re, im);
    endtask

    // stimulus
    initial
    begin
        start      = 1'b0;
        real_part  = '0;
        imag_part  = '0;
        rst_n      = 1'b0;
        sent_count = 0;
        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed corners: zero vector, half-axes, full scale, tiny values
        send_sample(16'sd0, 16'sd0);
        send_sample(16'sd32767, 16'sd0);
        send_sample(-16'sd32768, 16'sd0);
        send_sample(-16'sd1, 16'sd0);
        send_sample(16'sd1, 16'sd0);
        send_sample(16'sd0, 16'sd32767);
        send_sample(16'sd0, -16'sd32768);
        send_sample(16'sd0, 16'sd1);
        send_sample(16'sd0, -16'sd1);
        send_sample(-16'sd32768, -16'sd32768);
        send_sample(16'sd32767, 16'sd32767);
        send_sample(-16'sd32768, 16'sd32767);
        send_sample(16'sd32767, -16'sd32768);
        send_sample(-16'sd32768, 16'sd1);
        send_sample(-16'sd32768, -16'sd1);
        send_sample(-16'sd1, 16'sd1);
        send_sample(-16'sd1, -16'sd1);
        send_sample(16'sd1, 16'sd1);
        send_sample(16'sd1, -16'sd1);
        send_sample(16'sd12345, -16'sd23456);
        idle_cycle();

        // random part; no idling in the middle stretch
        for (int n = 0; n < RANDOM_REQUESTS; n++)
        begin
            if ((n < 600 || n >= 1000) && $urandom_range(0, 99) < 9)
                idle_cycle();
            send_random_sample();
        end
        @(negedge clk);
        start = 1'b0;

        // drain the pipeline
        while (pending_count != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("requests sent: %0d, results checked: %0d", sent_count, checked_count);
        $display("covered: zero vector, both real half-axes, extremes, tiny and diagonal samples");
        if (fail_count == 0 && pending_count == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

    // watchdog
    initial
    begin
        #200000;
        $display("simulation failed");
        $finish;
    end

endmodule
